// ----- rtl/pdmc_pkg.sv -----
// ----------------------------------------------------------------------------
// pdmc_pkg: shared widths, register indexes and helpers
// Field widths of the PD motor controller channels and its saturation helper.
// ----------------------------------------------------------------------------
package pdmc_pkg;

	// Channel field widths
	localparam int SUM_W      = 32;
	localparam int CNT_W      = 8;
	localparam int Q8_W       = 24;
	localparam int GAIN_W     = 32;
	localparam int SPEED_W    = 23;
	localparam int CMD_W      = 15;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// Shared multiplier: signed 33 x 25 bits
	localparam int MUL_A_W = GAIN_W + 1;
	localparam int MUL_B_W = Q8_W + 1;
	localparam int PROD_W  = MUL_A_W + MUL_B_W;
	localparam int ACC_W   = PROD_W;

	// Parameter defaults
	localparam int LINE_DEPTH_DEF = 8;
	localparam int DELAY_DEF      = 4;
	localparam int MAX_CMD_DEF    = 1000;

	// Register indexes
	localparam logic [CFG_IDX_W-1:0] REG_ERROR_SOURCE = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TARGET       = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PROP_GAIN    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_DERIV_GAIN   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_CMD_OFFSET   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_SPEED_SCALE  = 3'd5;

	// Clamp a 25-bit signed value to the signed 24-bit range
	function automatic logic signed [Q8_W-1:0] sat_q8(input logic signed [Q8_W:0] x);
		logic signed [Q8_W-1:0] r;
		if (x[Q8_W] != x[Q8_W-1]) begin
			r = x[Q8_W] ? {1'b1, {(Q8_W-1){1'b0}}} : {1'b0, {(Q8_W-1){1'b1}}};
		end else begin
			r = x[Q8_W-1:0];
		end
		return r;
	endfunction

endpackage

// ----- rtl/pdmc_if.sv -----
// ----------------------------------------------------------------------------
// pdmc_if: channel interfaces
// Sample, result and register write channels, each with valid and ready.
// ----------------------------------------------------------------------------
interface pdmc_sample_if;
	logic                                valid;
	logic                                ready;
	logic        [pdmc_pkg::SUM_W-1:0]   capture_sum;
	logic        [pdmc_pkg::CNT_W-1:0]   capture_count;
	logic signed [pdmc_pkg::Q8_W-1:0]    shaft_angle;

	modport source(output valid, capture_sum, capture_count, shaft_angle, input ready);
	modport sink(input valid, capture_sum, capture_count, shaft_angle, output ready);
endinterface

interface pdmc_result_if;
	logic                                valid;
	logic                                ready;
	logic        [pdmc_pkg::CMD_W-1:0]   drive_cmd;
	logic        [pdmc_pkg::SPEED_W-1:0] shaft_speed;
	logic signed [pdmc_pkg::Q8_W-1:0]    error_value;
	logic signed [pdmc_pkg::Q8_W-1:0]    error_slope;

	modport source(output valid, drive_cmd, shaft_speed, error_value, error_slope,
		input ready);
	modport sink(input valid, drive_cmd, shaft_speed, error_value, error_slope,
		output ready);
endinterface

interface pdmc_cfg_if;
	logic                              valid;
	logic                              ready;
	logic [pdmc_pkg::CFG_IDX_W-1:0]    index;
	logic [pdmc_pkg::CFG_DATA_W-1:0]   data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/pdmc_ram.sv -----
// ----------------------------------------------------------------------------
// pdmc_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module pdmc_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 8
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- rtl/pd_motor_controller.sv -----
// ----------------------------------------------------------------------------
// pd_motor_controller: proportional-derivative motor controller
// One command per control tick from speed or angle error and its delayed slope.
// ----------------------------------------------------------------------------
// Each transfer on sample delivers one control tick; one transfer on result follows. Speed is
// speed_scale*capture_count/capture_sum in Q8 (0 with no captures, saturated with a zero sum),
// the error is the target minus speed or angle (error_source), the slope is the error minus
// the one DELAY ticks back, and drive_cmd is round(prop_gain*e + deriv_gain*de + cmd_offset)
// clamped to [0, MAX_CMD]. The divide is skipped when there are no captures, the sum is zero or the
// quotient would saturate; otherwise a 23-step restoring divider makes one quotient bit per cycle,
// and a single shared 33x25 multiplier serves the speed scaling and both gain products. A finished
// result waits in its own register, so the next sample is taken while it is still pending. The user
// must write registers through cfg only while no tick is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module pd_motor_controller #(
	parameter int LINE_DEPTH = pdmc_pkg::LINE_DEPTH_DEF,
	parameter int DELAY      = pdmc_pkg::DELAY_DEF,
	parameter int MAX_CMD    = pdmc_pkg::MAX_CMD_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	pdmc_cfg_if.sink    cfg,
	pdmc_sample_if.sink sample,
	pdmc_result_if.source result
);

	localparam int PTR_W = $clog2(LINE_DEPTH);
	// Delays past the end of the line read the oldest entry
	localparam int OFF   = (DELAY >= LINE_DEPTH) ? LINE_DEPTH - 1 : DELAY;
	localparam int STEP_W = $clog2(pdmc_pkg::SPEED_W);
	localparam int DIVD_W = pdmc_pkg::SUM_W + pdmc_pkg::CNT_W;
	localparam int HI_W   = DIVD_W - pdmc_pkg::SPEED_W;

	// Sequencer codes
	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_SPDMUL  = 4'd1;
	localparam logic [3:0] S_DIVINIT = 4'd2;
	localparam logic [3:0] S_DIV     = 4'd3;
	localparam logic [3:0] S_ERR     = 4'd4;
	localparam logic [3:0] S_SLOPE   = 4'd5;
	localparam logic [3:0] S_PMUL    = 4'd6;
	localparam logic [3:0] S_DMUL    = 4'd7;
	localparam logic [3:0] S_DACC    = 4'd8;
	localparam logic [3:0] S_CMD     = 4'd9;

	// Configuration registers
	logic                                    err_src_q;
	logic signed [pdmc_pkg::Q8_W-1:0]        target_q;
	logic signed [pdmc_pkg::GAIN_W-1:0]      prop_gain_q;
	logic signed [pdmc_pkg::GAIN_W-1:0]      deriv_gain_q;
	logic signed [pdmc_pkg::Q8_W-1:0]        cmd_offset_q;
	logic        [pdmc_pkg::SUM_W-1:0]       speed_scale_q;

	// Tick working registers
	logic [3:0]                              state_q;
	logic [STEP_W-1:0]                       step_q;
	logic [pdmc_pkg::SUM_W-1:0]              sum_q;
	logic [pdmc_pkg::CNT_W-1:0]              cnt_q;
	logic signed [pdmc_pkg::Q8_W-1:0]        angle_q;
	logic [pdmc_pkg::SUM_W-1:0]              rem_q;
	logic [pdmc_pkg::SPEED_W-1:0]            quo_q;
	logic [pdmc_pkg::SPEED_W-1:0]            speed_q;
	logic signed [pdmc_pkg::Q8_W-1:0]        err_q;
	logic signed [pdmc_pkg::Q8_W-1:0]        slope_q;
	logic signed [pdmc_pkg::PROD_W-1:0]      prod_q;
	logic signed [pdmc_pkg::ACC_W-1:0]       acc_q;

	// Delay line bookkeeping
	logic [PTR_W-1:0]                        ptr_q;
	logic [LINE_DEPTH-1:0]                   vld_q;
	logic                                    old_vld_q;

	// Result register
	logic                                    out_vld_q;
	logic [pdmc_pkg::CMD_W-1:0]              out_cmd_q;
	logic [pdmc_pkg::SPEED_W-1:0]            out_speed_q;
	logic signed [pdmc_pkg::Q8_W-1:0]        out_err_q;
	logic signed [pdmc_pkg::Q8_W-1:0]        out_slope_q;

	logic                                    in_xfer;
	logic                                    out_xfer;
	logic                                    out_free;
	logic [PTR_W-1:0]                        ptr_nxt;
	logic [PTR_W-1:0]                        rd_idx;
	logic [pdmc_pkg::Q8_W-1:0]               line_rdata;
	logic signed [pdmc_pkg::Q8_W-1:0]        old_err;
	logic                                    line_we;

	logic signed [pdmc_pkg::MUL_A_W-1:0]     mul_a;
	logic signed [pdmc_pkg::MUL_B_W-1:0]     mul_b;
	logic [DIVD_W-1:0]                       dividend;
	logic [HI_W-1:0]                         div_hi;
	logic [pdmc_pkg::SUM_W:0]                trial;
	logic                                    trial_ge;
	logic [pdmc_pkg::SUM_W:0]                trial_sub;
	logic signed [pdmc_pkg::Q8_W:0]          err_diff;
	logic signed [pdmc_pkg::Q8_W:0]          slope_diff;
	logic [pdmc_pkg::ACC_W-25:0]             cmd_round;
	logic [pdmc_pkg::CMD_W-1:0]              cmd_val;

	assign cfg.ready    = 1'b1;
	assign sample.ready = (state_q == S_IDLE);
	assign in_xfer      = sample.valid && sample.ready;
	assign out_xfer     = out_vld_q && result.ready;
	assign out_free     = !out_vld_q || result.ready;

	assign result.valid       = out_vld_q;
	assign result.drive_cmd   = out_cmd_q;
	assign result.shaft_speed = out_speed_q;
	assign result.error_value = out_err_q;
	assign result.error_slope = out_slope_q;

	// Newest entry advances once per tick; the delayed entry sits OFF places behind it
	always_comb begin
		ptr_nxt = (ptr_q == PTR_W'(LINE_DEPTH - 1)) ? '0 : ptr_q + PTR_W'(1);
		if (ptr_nxt >= PTR_W'(OFF)) begin
			rd_idx = ptr_nxt - PTR_W'(OFF);
		end else begin
			rd_idx = ptr_nxt + PTR_W'(LINE_DEPTH - OFF);
		end
	end

	assign line_we = (state_q == S_SLOPE);

	pdmc_ram #(
		.WIDTH(pdmc_pkg::Q8_W),
		.DEPTH(LINE_DEPTH)
	) u_line (
		.clk  (clk),
		.we   (line_we),
		.waddr(ptr_q),
		.wdata(err_q),
		.re   (in_xfer),
		.raddr(rd_idx),
		.rdata(line_rdata)
	);

	// Entries never written read as zero
	assign old_err = old_vld_q ? signed'(line_rdata) : '0;

	// Shared multiplier operand select
	always_comb begin
		unique case (state_q)
			S_SPDMUL: begin
				mul_a = signed'({1'b0, speed_scale_q});
				mul_b = signed'({{(pdmc_pkg::MUL_B_W - pdmc_pkg::CNT_W){1'b0}}, cnt_q});
			end
			S_PMUL: begin
				mul_a = pdmc_pkg::MUL_A_W'(prop_gain_q);
				mul_b = pdmc_pkg::MUL_B_W'(err_q);
			end
			default: begin
				mul_a = pdmc_pkg::MUL_A_W'(deriv_gain_q);
				mul_b = pdmc_pkg::MUL_B_W'(slope_q);
			end
		endcase
	end

	// Divider datapath: restoring step, one quotient bit per cycle
	assign dividend  = prod_q[DIVD_W-1:0];
	assign div_hi    = dividend[DIVD_W-1:pdmc_pkg::SPEED_W];
	assign trial     = {rem_q, quo_q[pdmc_pkg::SPEED_W-1]};
	assign trial_ge  = trial >= {1'b0, sum_q};
	assign trial_sub = trial - {1'b0, sum_q};

	assign err_diff = (pdmc_pkg::Q8_W + 1)'(target_q)
		- (err_src_q ? (pdmc_pkg::Q8_W + 1)'(angle_q)
			: signed'({2'b00, speed_q}));
	assign slope_diff = (pdmc_pkg::Q8_W + 1)'(err_q) - (pdmc_pkg::Q8_W + 1)'(old_err);

	// Round half up from Q24, clamp to [0, MAX_CMD]
	always_comb begin
		cmd_round = acc_q[pdmc_pkg::ACC_W-1:24]
			+ (pdmc_pkg::ACC_W - 24)'(acc_q[23]);
		if (acc_q[pdmc_pkg::ACC_W-1] || acc_q == '0) begin
			cmd_val = '0;
		end else if (cmd_round > (pdmc_pkg::ACC_W - 24)'(MAX_CMD)) begin
			cmd_val = pdmc_pkg::CMD_W'(MAX_CMD);
		end else begin
			cmd_val = cmd_round[pdmc_pkg::CMD_W-1:0];
		end
	end

	// Register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_src_q     <= 1'b0;
			target_q      <= '0;
			prop_gain_q   <= '0;
			deriv_gain_q  <= '0;
			cmd_offset_q  <= '0;
			speed_scale_q <= '0;
		end else if (cfg.valid && cfg.ready) begin
			unique case (cfg.index)
				pdmc_pkg::REG_ERROR_SOURCE: err_src_q     <= cfg.data[0];
				pdmc_pkg::REG_TARGET:       target_q      <= cfg.data[pdmc_pkg::Q8_W-1:0];
				pdmc_pkg::REG_PROP_GAIN:    prop_gain_q   <= cfg.data;
				pdmc_pkg::REG_DERIV_GAIN:   deriv_gain_q  <= cfg.data;
				pdmc_pkg::REG_CMD_OFFSET:   cmd_offset_q  <= cfg.data[pdmc_pkg::Q8_W-1:0];
				pdmc_pkg::REG_SPEED_SCALE:  speed_scale_q <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	// Sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			step_q    <= '0;
			ptr_q     <= '0;
			vld_q     <= '0;
			old_vld_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			// Raise the result as the command step completes, drop it on its transfer
			if (state_q == S_CMD && out_free) begin
				out_vld_q <= 1'b1;
			end else if (out_xfer) begin
				out_vld_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						ptr_q     <= ptr_nxt;
						old_vld_q <= vld_q[rd_idx];
						state_q   <= S_SPDMUL;
					end
				end
				S_SPDMUL: begin
					state_q <= S_DIVINIT;
				end
				S_DIVINIT: begin
					step_q <= '0;
					// Skip the divide when the quotient is known already
					if (cnt_q == '0 || sum_q == '0
						|| pdmc_pkg::SUM_W'(div_hi) >= sum_q) begin
						state_q <= S_ERR;
					end else begin
						state_q <= S_DIV;
					end
				end
				S_DIV: begin
					step_q <= step_q + STEP_W'(1);
					if (step_q == STEP_W'(pdmc_pkg::SPEED_W - 1)) begin
						state_q <= S_ERR;
					end
				end
				S_ERR: begin
					state_q <= S_SLOPE;
				end
				S_SLOPE: begin
					vld_q[ptr_q] <= 1'b1;
					state_q      <= S_PMUL;
				end
				S_PMUL: begin
					state_q <= S_DMUL;
				end
				S_DMUL: begin
					state_q <= S_DACC;
				end
				S_DACC: begin
					state_q <= S_CMD;
				end
				S_CMD: begin
					// Hold until the result register is free
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			sum_q   <= sample.capture_sum;
			cnt_q   <= sample.capture_count;
			angle_q <= sample.shaft_angle;
		end
		if (state_q == S_SPDMUL || state_q == S_PMUL || state_q == S_DMUL) begin
			prod_q <= mul_a * mul_b;
		end
		if (state_q == S_DIVINIT) begin
			rem_q <= pdmc_pkg::SUM_W'(div_hi);
			quo_q <= dividend[pdmc_pkg::SPEED_W-1:0];
			if (cnt_q == '0) begin
				speed_q <= '0;
			end else begin
				speed_q <= '1;
			end
		end
		if (state_q == S_DIV) begin
			rem_q <= trial_ge ? trial_sub[pdmc_pkg::SUM_W-1:0] : trial[pdmc_pkg::SUM_W-1:0];
			quo_q <= {quo_q[pdmc_pkg::SPEED_W-2:0], trial_ge};
			if (step_q == STEP_W'(pdmc_pkg::SPEED_W - 1)) begin
				speed_q <= {quo_q[pdmc_pkg::SPEED_W-2:0], trial_ge};
			end
		end
		if (state_q == S_ERR) begin
			err_q <= pdmc_pkg::sat_q8(err_diff);
		end
		if (state_q == S_SLOPE) begin
			slope_q <= pdmc_pkg::sat_q8(slope_diff);
		end
		if (state_q == S_PMUL) begin
			acc_q <= pdmc_pkg::ACC_W'(cmd_offset_q) <<< 16;
		end
		if (state_q == S_DMUL || state_q == S_DACC) begin
			acc_q <= acc_q + prod_q;
		end
		if (state_q == S_CMD && out_free) begin
			out_cmd_q   <= cmd_val;
			out_speed_q <= speed_q;
			out_err_q   <= err_q;
			out_slope_q <= slope_q;
		end
	end

`ifndef SYNTHESIS
	a_result_from_cmd: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_vld_q) |-> $past(state_q == S_CMD))
		else $error("result raised outside the command step");

	a_cmd_clamped: assert property (@(posedge clk) disable iff (!arst_n)
		out_vld_q |-> (out_cmd_q <= pdmc_pkg::CMD_W'(MAX_CMD)))
		else $error("drive command above clamp");

	a_div_steps: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (step_q < STEP_W'(pdmc_pkg::SPEED_W)))
		else $error("divider ran past its quotient width");

	a_no_capture_speed: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIVINIT && cnt_q == '0) |=> (speed_q == '0 && state_q == S_ERR))
		else $error("speed not zero without captures");

	a_line_marked: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SLOPE) |=> vld_q[$past(ptr_q)])
		else $error("delay line entry not marked after write");
`endif

endmodule
